// File: hw/rtl/sdf_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_pkg
// Shared constants, codes and controller/datapath signal groups for the
// signed radix digit formatter.
// -----------------------------------------------------------------------------
package sdf_pkg;

   localparam int VALUE_W         = 32;
   localparam int SYMBOL_W        = 8;
   localparam int FAULT_W         = 2;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 64;
   localparam int ALPHA_CAP       = 16;
   localparam int ALPHA_W         = ALPHA_CAP * SYMBOL_W;
   localparam int SYM_IDX_W       = $clog2(ALPHA_CAP);
   localparam int MAX_SYMBOLS_DEF = 16;

   // divider retires this many quotient bits per cycle
   localparam int BITS_PER_STEP   = 8;
   localparam int STEPS_PER_DIGIT = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

   localparam int MAX_DIGITS      = 32;
   localparam int DIGIT_IDX_W     = $clog2(MAX_DIGITS);
   localparam int DIGIT_CNT_W     = $clog2(MAX_DIGITS + 1);

   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 4'd1;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_SHORT = 2'd1,
      FAULT_ALPHA = 2'd2
   } fault_type;

   typedef struct packed {
      logic start;
      logic chk_step;
      logic div_step;
      logic load_sign;
      logic load_digit;
      logic load_fault;
   } cmd_type;

   typedef struct packed {
      logic short_alpha;
      logic chk_bad;
      logic chk_last;
      logic digit_end;
      logic more;
      logic neg;
      logic nd_one;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/sdf_req_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_req_if
// Input channel: one signed value per word.
// -----------------------------------------------------------------------------
interface sdf_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sdf_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sdf_rsp_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_rsp_if
// Result channel: one character per word, with end marker and fault code.
// -----------------------------------------------------------------------------
interface sdf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sdf_pkg::SYMBOL_W-1:0]  symbol;
   logic                          last;
   logic [sdf_pkg::FAULT_W-1:0]   fault;

   modport source (output valid, output symbol, output last, output fault, input ready);
   modport sink   (input valid, input symbol, input last, input fault, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sdf_csr_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_csr_if
// Register write channel: register index and write data.
// -----------------------------------------------------------------------------
interface sdf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sdf_pkg::CSR_INDEX_W-1:0] index;
   logic [sdf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sdf_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_datapath
// Alphabet registers, alphabet checker, iterative divider, digit store and
// output word register.
// -----------------------------------------------------------------------------
module sdf_datapath #(
   parameter int MAX_SYMBOLS = sdf_pkg::MAX_SYMBOLS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write,
   input  wire  [sdf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [sdf_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire  signed [sdf_pkg::VALUE_W-1:0]  value,
   input  wire  sdf_pkg::cmd_type              cmd,
   output sdf_pkg::status_type                 sts,
   output logic [sdf_pkg::SYMBOL_W-1:0]        out_symbol,
   output logic                                out_last,
   output logic [sdf_pkg::FAULT_W-1:0]         out_fault
);

   localparam int DIG_W  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int BASE_W = $clog2(MAX_SYMBOLS + 1);
   localparam int REM_W  = DIG_W + 1;
   localparam int VW     = sdf_pkg::VALUE_W;

   function automatic logic [sdf_pkg::SYMBOL_W-1:0] sym_at(
      input logic [sdf_pkg::ALPHA_W-1:0]   alpha,
      input logic [sdf_pkg::SYM_IDX_W-1:0] idx
   );
      sym_at = alpha[idx*sdf_pkg::SYMBOL_W +: sdf_pkg::SYMBOL_W];
   endfunction

   logic [sdf_pkg::CSR_DATA_W-1:0]   sym_low_ff,  sym_low_in;
   logic [sdf_pkg::CSR_DATA_W-1:0]   sym_high_ff, sym_high_in;
   logic [sdf_pkg::ALPHA_W-1:0]      alpha;

   logic [VW-1:0]                    mag_ff,  mag_in;
   logic                             neg_ff,  neg_in;
   logic [BASE_W-1:0]                base_ff, base_in;
   logic [sdf_pkg::FAULT_W-1:0]      fault_ff, fault_in;
   logic [DIG_W-1:0]                 chk_idx_ff, chk_idx_in;
   logic [DIG_W-1:0]                 rem_ff,  rem_in;
   logic [sdf_pkg::STEP_CNT_W-1:0]   step_ff, step_in;
   logic [sdf_pkg::DIGIT_CNT_W-1:0]  nd_ff,   nd_in;
   logic [DIG_W-1:0]                 digit_ff [sdf_pkg::MAX_DIGITS];
   logic [DIG_W-1:0]                 rd_digit_ff;

   logic [sdf_pkg::SYMBOL_W-1:0]     out_symbol_ff, out_symbol_in;
   logic                             out_last_ff,   out_last_in;
   logic [sdf_pkg::FAULT_W-1:0]      out_fault_ff,  out_fault_in;

   logic [BASE_W-1:0]                len_comb;
   logic [sdf_pkg::SYMBOL_W-1:0]     chk_sym;
   logic                             chk_bad;
   logic [VW-1:0]                    raw;
   logic [VW-1:0]                    mag_next;
   logic [DIG_W-1:0]                 rem_next;
   logic [REM_W-1:0]                 part;
   logic [sdf_pkg::DIGIT_IDX_W-1:0]  rd_idx;
   logic                             digit_end;

   assign alpha = {sym_high_ff, sym_low_ff};

   // alphabet length: position of the first zero byte
   always_comb begin
      len_comb = BASE_W'(MAX_SYMBOLS);
      for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (sym_at(alpha, sdf_pkg::SYM_IDX_W'(i)) == '0) begin
            len_comb = BASE_W'(i);
         end
      end
   end

   // one symbol a cycle against sign characters and every later symbol
   always_comb begin
      chk_sym = sym_at(alpha, sdf_pkg::SYM_IDX_W'(chk_idx_ff));
      chk_bad = (chk_sym == sdf_pkg::CH_MINUS) || (chk_sym == sdf_pkg::CH_PLUS);
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if ((j > int'(chk_idx_ff)) && (j < int'(base_ff)) &&
             (sym_at(alpha, sdf_pkg::SYM_IDX_W'(j)) == chk_sym)) begin
            chk_bad = 1'b1;
         end
      end
   end

   // restoring division, several quotient bits a cycle
   always_comb begin
      mag_next = mag_ff;
      rem_next = rem_ff;
      for (int b = 0; b < sdf_pkg::BITS_PER_STEP; b++) begin
         part     = {rem_next, mag_next[VW-1]};
         mag_next = {mag_next[VW-2:0], 1'b0};
         if (part >= REM_W'(base_ff)) begin
            part        = part - REM_W'(base_ff);
            mag_next[0] = 1'b1;
         end
         rem_next = part[DIG_W-1:0];
      end
   end

   assign digit_end = (step_ff == sdf_pkg::STEP_CNT_W'(sdf_pkg::STEPS_PER_DIGIT - 1));
   assign raw       = value;
   assign rd_idx    = sdf_pkg::DIGIT_IDX_W'(nd_in - sdf_pkg::DIGIT_CNT_W'(1));

   always_comb begin
      sym_low_in    = sym_low_ff;
      sym_high_in   = sym_high_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      base_in       = base_ff;
      fault_in      = fault_ff;
      chk_idx_in    = chk_idx_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      nd_in         = nd_ff;
      out_symbol_in = out_symbol_ff;
      out_last_in   = out_last_ff;
      out_fault_in  = out_fault_ff;

      if (csr_write) begin
         unique case (csr_index)
            sdf_pkg::CSR_SYMBOLS_LOW:  sym_low_in  = csr_data;
            sdf_pkg::CSR_SYMBOLS_HIGH: sym_high_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.start) begin
         neg_in     = raw[VW-1];
         mag_in     = raw[VW-1] ? (~raw + VW'(1)) : raw;
         base_in    = len_comb;
         fault_in   = (len_comb < BASE_W'(2)) ? sdf_pkg::FAULT_SHORT : sdf_pkg::FAULT_NONE;
         chk_idx_in = '0;
         rem_in     = '0;
         step_in    = '0;
         nd_in      = '0;
      end

      if (cmd.chk_step) begin
         chk_idx_in = chk_idx_ff + DIG_W'(1);
         if (chk_bad) begin
            fault_in = sdf_pkg::FAULT_ALPHA;
         end
      end

      if (cmd.div_step) begin
         mag_in  = mag_next;
         step_in = step_ff + sdf_pkg::STEP_CNT_W'(1);
         if (digit_end) begin
            rem_in = '0;
            nd_in  = nd_ff + sdf_pkg::DIGIT_CNT_W'(1);
         end else begin
            rem_in = rem_next;
         end
      end

      if (cmd.load_sign) begin
         out_symbol_in = sdf_pkg::CH_MINUS;
         out_last_in   = 1'b0;
         out_fault_in  = sdf_pkg::FAULT_NONE;
      end

      if (cmd.load_digit) begin
         out_symbol_in = sym_at(alpha, sdf_pkg::SYM_IDX_W'(rd_digit_ff));
         out_last_in   = (nd_ff == sdf_pkg::DIGIT_CNT_W'(1));
         out_fault_in  = sdf_pkg::FAULT_NONE;
         nd_in         = nd_ff - sdf_pkg::DIGIT_CNT_W'(1);
      end

      if (cmd.load_fault) begin
         out_symbol_in = '0;
         out_last_in   = 1'b1;
         out_fault_in  = fault_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
         nd_ff       <= '0;
         step_ff     <= '0;
      end else begin
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
         nd_ff       <= nd_in;
         step_ff     <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      base_ff       <= base_in;
      fault_ff      <= fault_in;
      chk_idx_ff    <= chk_idx_in;
      rem_ff        <= rem_in;
      out_symbol_ff <= out_symbol_in;
      out_last_ff   <= out_last_in;
      out_fault_ff  <= out_fault_in;
   end

   // digit store, least significant digit first
   // read one digit ahead of the count, the digit being written is forwarded
   always_ff @(posedge clock) begin
      if (cmd.div_step && digit_end) begin
         digit_ff[nd_ff[sdf_pkg::DIGIT_IDX_W-1:0]] <= rem_next;
         rd_digit_ff                               <= rem_next;
      end else begin
         rd_digit_ff <= digit_ff[rd_idx];
      end
   end

   always_comb begin
      sts.short_alpha = (fault_ff == sdf_pkg::FAULT_SHORT);
      sts.chk_bad     = chk_bad;
      sts.chk_last    = (REM_W'(chk_idx_ff) + REM_W'(1)) == REM_W'(base_ff);
      sts.digit_end   = digit_end;
      sts.more        = (mag_next != '0) &&
                        (nd_ff != sdf_pkg::DIGIT_CNT_W'(sdf_pkg::MAX_DIGITS - 1));
      sts.neg         = neg_ff;
      sts.nd_one      = (nd_ff == sdf_pkg::DIGIT_CNT_W'(1));
   end

   assign out_symbol = out_symbol_ff;
   assign out_last   = out_last_ff;
   assign out_fault  = out_fault_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sdf_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer: alphabet check, digit division, then character output.
// -----------------------------------------------------------------------------
module sdf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  wire sdf_pkg::status_type sts,
   output sdf_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_SIGN   = 6'b001000,
      ST_DIGIT  = 6'b010000,
      ST_FAULT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.short_alpha) begin
               state_in = ST_FAULT;
            end else begin
               cmd.chk_step = 1'b1;
               if (sts.chk_bad) begin
                  state_in = ST_FAULT;
               end else if (sts.chk_last) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.digit_end && !sts.more) begin
               state_in = sts.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.load_sign = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               cmd.load_digit = 1'b1;
               rsp_valid_in   = 1'b1;
               if (sts.nd_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FAULT: begin
            if (slot_free) begin
               cmd.load_fault = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: hw/rtl/signed_radix_digit_formatter_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// signed_radix_digit_formatter_core
// Writes signed 32-bit values as text in a base set by a digit alphabet.
// -----------------------------------------------------------------------------
// One value is taken at a time. The alphabet (the leading nonzero bytes of the
// two symbol registers, symbol 0 in the low byte) is checked at one symbol a
// cycle, stopping early when a fault is found. A bad alphabet gives a single
// word with symbol 0, last set and the fault code. Otherwise each digit is
// formed in the iterative divider (8 quotient bits a cycle), then the text
// leaves at one character a cycle from the output register while the receiver
// is ready, '-' first for negative values and last set on the final digit.
// The next value is taken as soon as the final character is loaded into the
// output register. Symbol registers are to be written by the user only while
// no value is in flight; the core has no guard for this.
// -----------------------------------------------------------------------------
module signed_radix_digit_formatter_core #(
   parameter int MAX_SYMBOLS = sdf_pkg::MAX_SYMBOLS_DEF
) (
   input wire          clock,
   input wire          reset,
   sdf_req_if.sink     req_bus,
   sdf_rsp_if.source   rsp_bus,
   sdf_csr_if.sink     csr_bus
);

   sdf_pkg::cmd_type    cmd;
   sdf_pkg::status_type sts;
   logic                csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdf_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .value      (req_bus.value),
      .cmd        (cmd),
      .sts        (sts),
      .out_symbol (rsp_bus.symbol),
      .out_last   (rsp_bus.last),
      .out_fault  (rsp_bus.fault)
   );

endmodule
`default_nettype wire

// File: tb/sdf_text_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sdf_text_checker
// Passive checker for the signed radix digit formatter. It tracks the symbol
// registers from the write channel. For every accepted value it queues the
// characters the core should send, or the single fault word. Each result word
// is then compared field by field against the oldest queued character.
// -----------------------------------------------------------------------------
module sdf_text_checker #(
   parameter int MAX_SYMBOLS = sdf_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [sdf_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic        [sdf_pkg::SYMBOL_W-1:0]  rsp_symbol,
   input  logic                                 rsp_last,
   input  logic        [sdf_pkg::FAULT_W-1:0]   rsp_fault,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic        [sdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [sdf_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                   fail_count,
   output int                                   pending
);
   import sdf_pkg::*;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      fault_type           fault;
   } char_word_t;

   localparam int SYMBOL_LIMIT = (MAX_SYMBOLS > ALPHA_CAP) ? ALPHA_CAP : MAX_SYMBOLS;

   // {symbols_high, symbols_low}, symbol 0 in the lowest byte
   logic [ALPHA_W-1:0] alphabet;
   char_word_t         text_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      alphabet   = '0;
   end

   function automatic logic [SYMBOL_W-1:0] symbol_at(input int idx);
      return alphabet[SYMBOL_W*idx +: SYMBOL_W];
   endfunction

   function automatic int alphabet_length();
      int len;
      len = 0;
      while (len < SYMBOL_LIMIT && symbol_at(len) != '0)
         len++;
      return len;
   endfunction

   function automatic fault_type alphabet_fault(input int len);
      fault_type code;
      logic [SYMBOL_W-1:0] sym;
      code = FAULT_NONE;
      if (len < 2) begin
         code = FAULT_SHORT;
      end else begin
         for (int i = 0; i < len; i++) begin
            sym = symbol_at(i);
            if (sym == CH_MINUS || sym == CH_PLUS)
               code = FAULT_ALPHA;
            for (int j = i + 1; j < len; j++)
               if (symbol_at(j) == sym)
                  code = FAULT_ALPHA;
         end
      end
      return code;
   endfunction

   task automatic queue_text(input logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      int                 digit_q[$];
      int                 len;
      fault_type          code;
      len  = alphabet_length();
      code = alphabet_fault(len);
      if (code != FAULT_NONE) begin
         text_q.push_back('{'0, 1'b1, code});
      end else begin
         radix = len;
         mag   = value;
         // magnitude kept unsigned so the most negative value survives
         if (value[VALUE_W-1])
            mag = -mag;
         do begin
            digit_q.push_front(int'(mag % radix));
            mag = mag / radix;
         end while (mag != 0);
         if (value[VALUE_W-1])
            text_q.push_back('{CH_MINUS, 1'b0, FAULT_NONE});
         foreach (digit_q[i])
            text_q.push_back('{symbol_at(digit_q[i]), (i == digit_q.size() - 1), FAULT_NONE});
      end
   endtask

   always @(posedge clock) begin : watch
      char_word_t want;
      if (reset) begin
         alphabet = '0;
         text_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (text_q.size() == 0) begin
               $error("unexpected word: symbol %h last %b fault %0d",
                      rsp_symbol, rsp_last, rsp_fault);
               fail_count++;
            end else begin
               want = text_q.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  $error("symbol: expected %h, got %h", want.symbol, rsp_symbol);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_fault !== want.fault) begin
                  $error("fault: expected %0d, got %0d", want.fault, rsp_fault);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SYMBOLS_LOW)
               alphabet[CSR_DATA_W-1:0] = csr_data;
            else if (csr_index == CSR_SYMBOLS_HIGH)
               alphabet[ALPHA_W-1:CSR_DATA_W] = csr_data;
         end
         if (req_valid && req_ready)
            queue_text(req_value);
      end
      pending = text_q.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the signed radix digit formatter core.
// A directed pass covers fault alphabets, extreme values and bases, and
// ignored register writes. Random phases follow, each with a fresh alphabet.
// Both channels idle at random, and one phase holds the receiver off long
// enough to back up the input. Checking is done by sdf_text_checker.
// -----------------------------------------------------------------------------
module tb;
   import sdf_pkg::*;

   // no register behind this index
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'hF;
   localparam int LONG_HOLD   = 400;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 38;
   localparam int SETTLE      = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   bit   req_steady;
   bit   rsp_steady;
   bit   hold_rsp;

   sdf_req_if req_bus ();
   sdf_rsp_if rsp_bus ();
   sdf_csr_if csr_bus ();

   signed_radix_digit_formatter_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sdf_text_checker text_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_value  (req_bus.value),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_symbol (rsp_bus.symbol),
      .rsp_last   (rsp_bus.last),
      .rsp_fault  (rsp_bus.fault),
      .csr_valid  (csr_bus.valid),
      .csr_ready  (csr_bus.ready),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: raw = 32'h8000_0000;
               1: raw = 32'h7FFF_FFFF;
               2: raw = '0;
               default: raw = '1;
            endcase
         end
         1, 2: raw = 32'($urandom_range(0, 40)) - 32'd20;
         3: begin
            raw = raw >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               raw = -raw;
         end
         default: ;
      endcase
      return raw;
   endfunction

   // mostly sound alphabets of random base, some short, signed or repeated
   function automatic logic [ALPHA_W-1:0] random_alphabet();
      logic [ALPHA_W-1:0]  alpha;
      logic [SYMBOL_W-1:0] sym;
      bit                  clash;
      int                  len;
      int                  pick;
      int                  i;
      int                  j;
      alpha = '0;
      len   = $urandom_range(2, ALPHA_CAP);
      for (i = 0; i < len; i++) begin
         do begin
            sym   = $urandom_range(1, 255);
            clash = (sym == CH_MINUS || sym == CH_PLUS);
            for (j = 0; j < i; j++)
               if (alpha[SYMBOL_W*j +: SYMBOL_W] == sym)
                  clash = 1'b1;
         end while (clash);
         alpha[SYMBOL_W*i +: SYMBOL_W] = sym;
      end
      // junk beyond the terminating zero byte
      if (len < ALPHA_CAP - 1 && $urandom_range(0, 1))
         for (i = len + 1; i < ALPHA_CAP; i++)
            alpha[SYMBOL_W*i +: SYMBOL_W] = $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         j = $urandom_range(0, 1);
         alpha[SYMBOL_W*j +: SYMBOL_W] = '0;
      end else if (pick < 12) begin
         j = $urandom_range(0, len - 1);
         alpha[SYMBOL_W*j +: SYMBOL_W] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
      end else if (pick < 18) begin
         i = $urandom_range(1, len - 1);
         j = $urandom_range(0, i - 1);
         alpha[SYMBOL_W*i +: SYMBOL_W] = alpha[SYMBOL_W*j +: SYMBOL_W];
      end
      return alpha;
   endfunction

   // called and returns at a falling edge; valid stays high unless a gap follows
   task automatic send_value(input logic signed [VALUE_W-1:0] value);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      gap = 0;
      if (!req_steady && $urandom_range(0, 99) < 30)
         gap = idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic set_alphabet(input logic [ALPHA_W-1:0] alpha, input bit stray);
      bit low_first;
      low_first = $urandom_range(0, 1);
      if (low_first)
         csr_write(CSR_SYMBOLS_LOW, alpha[CSR_DATA_W-1:0]);
      else
         csr_write(CSR_SYMBOLS_HIGH, alpha[ALPHA_W-1:CSR_DATA_W]);
      if (stray)
         csr_write(CSR_UNMAPPED, {$urandom, $urandom});
      if (low_first)
         csr_write(CSR_SYMBOLS_HIGH, alpha[ALPHA_W-1:CSR_DATA_W]);
      else
         csr_write(CSR_SYMBOLS_LOW, alpha[CSR_DATA_W-1:0]);
      csr_bus.valid <= 1'b0;
   endtask

   // stop offering and wait for every queued character
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // receiver
   initial begin
      int gap_left;
      gap_left      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp       = 1'b0;
            gap_left       = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
            gap_left       = idle_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [ALPHA_W-1:0] alpha;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_SYMBOLS_LOW;
      csr_bus.data  = '0;
      req_steady    = 1'b0;
      rsp_steady    = 1'b0;
      hold_rsp      = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty alphabet after reset
      send_value(0);
      drain();
      // one symbol, junk past the zero byte
      set_alphabet({64'h0, 64'h0041_4200_0000_0058}, 1'b0);
      send_value(5);
      drain();
      // decimal, with a write to an index that has no register
      set_alphabet({64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130}, 1'b1);
      send_value(0);
      send_value(-32'sd1);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(32'sd1_000_000_000);
      drain();
      // binary, high register all ones and ignored
      set_alphabet({64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_3130}, 1'b0);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(0);
      drain();
      // full sixteen symbols at the top of the byte range
      set_alphabet({64'hFFFE_FDFC_FBFA_F9F8, 64'hF7F6_F5F4_F3F2_F1F0}, 1'b0);
      send_value(32'sh8000_0000);
      send_value(-32'sd1);
      send_value(32'sh7FFF_FFFF);
      drain();
      // sign bytes after the zero byte do not count
      set_alphabet({64'h1234_5678_9ABC_DEF0, 64'hFF2D_2B00_0000_6261}, 1'b0);
      send_value(5);
      send_value(-32'sd6);
      drain();
      set_alphabet({64'h0, 64'h0000_0000_0033_2D31}, 1'b0);
      send_value(1);
      drain();
      // plus sign as the sixteenth symbol
      set_alphabet({64'h2B46_4544_4342_4139, 64'h3837_3635_3433_3231}, 1'b0);
      send_value(0);
      drain();
      set_alphabet({64'h0, 64'h0000_0000_6163_6261}, 1'b0);
      send_value(-32'sd7);
      drain();
      set_alphabet('1, 1'b0);
      send_value(32'sh7FFF_FFFF);
      drain();
      set_alphabet({64'h0, 64'h0000_0000_0000_FF01}, 1'b0);
      send_value(-32'sd1);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         alpha = random_alphabet();
         set_alphabet(alpha, $urandom_range(0, 3) == 0);
         req_steady = (phase % 4 == 1);
         rsp_steady = req_steady;
         // back up the core: receiver held off while words keep coming
         if (phase == 2) begin
            req_steady = 1'b1;
            hold_rsp   = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_value(random_value());
      end

      drain();
      rsp_steady = 1'b1;
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
